/* design/tlfd_pkg.sv */
package tlfd_pkg;

    localparam int POS_W       = 34;
    localparam int HDR_BYTES   = 12;
    localparam int IDENT_BYTES = 4;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_ZERO_ID = 2'd2
    } t_status;

    localparam logic [1:0] SEC_DATA  = 2'd0;
    localparam logic [1:0] SEC_TIME  = 2'd1;
    localparam logic [1:0] SEC_DESC  = 2'd2;
    localparam logic [1:0] SEC_UNITS = 2'd3;

    typedef struct packed {
        logic        byte_valid;
        logic [7:0]  payload_byte;
        logic [1:0]  section;
        logic        frame_done;
        logic        is_identification;
        logic [31:0] frame_id;
        t_status     frame_status;
    } t_result;

endpackage

/* design/tlfd_core.sv */
module tlfd_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    output tlfd_pkg::t_result o_res
);
    import tlfd_pkg::*;

    localparam logic [POS_W-1:0] POS_MAX   = {POS_W{1'b1}};
    localparam logic [POS_W-1:0] HDR_END   = POS_W'(HDR_BYTES);
    localparam logic [POS_W-1:0] IDENT_END = POS_W'(HDR_BYTES + IDENT_BYTES);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [31:0]      r_hdr_id, n_hdr_id;
    logic [31:0]      r_first_len, n_first_len;
    logic [31:0]      r_second_len, n_second_len;
    logic [31:0]      r_ident_id, n_ident_id;

    logic             w_ident;
    logic [POS_W-1:0] w_mid;
    logic [POS_W-1:0] w_end;
    logic [POS_W:0]   w_count;
    logic             w_in_body;

    function automatic logic [31:0] put_byte(input logic [31:0] word,
                                              input logic [1:0] slot,
                                              input logic [7:0] b);
        logic [31:0] w;
        begin
            w = word;
            w[{~slot, 3'b000} +: 8] = b;
            return w;
        end
    endfunction

    always_comb begin
        n_hdr_id     = r_hdr_id;
        n_first_len  = r_first_len;
        n_second_len = r_second_len;
        n_ident_id   = r_ident_id;
        if (r_pos < POS_W'(4)) begin
            n_hdr_id = put_byte(r_hdr_id, r_pos[1:0], i_byte);
        end else if (r_pos < POS_W'(8)) begin
            n_first_len = put_byte(r_first_len, r_pos[1:0], i_byte);
        end else if (r_pos < HDR_END) begin
            n_second_len = put_byte(r_second_len, r_pos[1:0], i_byte);
        end

        w_ident   = (n_hdr_id == 32'd0);
        w_mid     = HDR_END + POS_W'(n_first_len);
        w_end     = w_mid + POS_W'(n_second_len);
        w_count   = {1'b0, r_pos} + (POS_W+1)'(1);
        w_in_body = (r_pos >= HDR_END);

        if (w_in_body && w_ident && r_pos < IDENT_END) begin
            n_ident_id = put_byte(r_ident_id, r_pos[1:0], i_byte);
        end

        o_res = '0;
        if (w_in_body) begin
            if (!w_ident) begin
                if (r_pos < w_mid) begin
                    o_res.byte_valid = 1'b1;
                    o_res.section    = SEC_DATA;
                end else if (r_pos < w_end) begin
                    o_res.byte_valid = 1'b1;
                    o_res.section    = SEC_TIME;
                end
            end else if (n_first_len >= 32'(IDENT_BYTES)) begin
                if (r_pos >= IDENT_END && r_pos < w_mid) begin
                    o_res.byte_valid = 1'b1;
                    o_res.section    = SEC_DESC;
                end else if (r_pos >= w_mid && r_pos < w_end) begin
                    o_res.byte_valid = 1'b1;
                    o_res.section    = SEC_UNITS;
                end
            end
        end
        if (o_res.byte_valid) begin
            o_res.payload_byte = i_byte;
        end

        o_res.frame_done = i_last;
        if (i_last) begin
            o_res.is_identification = w_ident;
            o_res.frame_id          = w_ident ? n_ident_id : n_hdr_id;
            if (w_count < (POS_W+1)'(HDR_BYTES) || w_count < {1'b0, w_end}) begin
                o_res.frame_status = ST_INVALID;
            end else if (w_ident && n_first_len < 32'(IDENT_BYTES)) begin
                o_res.frame_status = ST_INVALID;
            end else if (w_ident && n_ident_id == 32'd0) begin
                o_res.frame_status = ST_ZERO_ID;
            end else begin
                o_res.frame_status = ST_OK;
            end
        end

        n_pos = (r_pos < POS_MAX) ? r_pos + POS_W'(1) : r_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_hdr_id     <= '0;
            r_first_len  <= '0;
            r_second_len <= '0;
            r_ident_id   <= '0;
        end else if (i_en) begin
            if (i_last) begin
                r_pos        <= '0;
                r_hdr_id     <= '0;
                r_first_len  <= '0;
                r_second_len <= '0;
                r_ident_id   <= '0;
            end else begin
                r_pos        <= n_pos;
                r_hdr_id     <= n_hdr_id;
                r_first_len  <= n_first_len;
                r_second_len <= n_second_len;
                r_ident_id   <= n_ident_id;
            end
        end
    end

endmodule

/* design/tagged_length_frame_deframer_unit.sv */
// Frame deframer: takes one frame byte per transfer and returns exactly one
// result per byte, the section byte (tagged data, time, description or units)
// or an empty slot for header, identifier and trailing bytes, with frame kind,
// id and status added on the result of the last byte. Section bytes leave
// before the status is known, so a consumer must drop a frame whose status is
// not ok. A byte is accepted in every cycle while o_in_stall is low; each byte
// passes the input register, then one combinational pass of header capture and
// a 34-bit length add and compare, into the result register. A skid register
// behind the result register keeps input acceptance going for one more byte
// when the output stalls. All frame state returns to zero after a last byte.
module tagged_length_frame_deframer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_frame_end,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_byte_valid,
    output logic [7:0]  o_payload_byte,
    output logic [1:0]  o_section,
    output logic        o_frame_done,
    output logic        o_is_identification,
    output logic [31:0] o_frame_id,
    output logic [1:0]  o_frame_status
);
    import tlfd_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_end;
    logic       r_out_valid;
    t_result    r_out;
    logic       r_skd_valid;
    t_result    r_skd;
    t_result    w_res;
    logic       w_adv;
    logic       w_take;
    logic       w_in_acc;

    assign w_take   = r_out_valid && !i_out_stall;
    assign w_adv    = r_in_valid && !r_skd_valid;
    assign w_in_acc = i_in_valid && !o_in_stall;
    assign o_in_stall = r_in_valid && r_skd_valid;

    tlfd_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_byte  (r_in_byte),
        .i_last  (r_in_end),
        .o_res   (w_res)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_byte <= i_frame_byte;
            r_in_end  <= i_frame_end;
        end
    end

    // result register and skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else if (r_skd_valid) begin
            if (w_take) begin
                r_skd_valid <= 1'b0;
            end
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
            if (r_out_valid && !w_take) begin
                r_skd_valid <= 1'b1;
            end
        end else if (w_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skd_valid) begin
            if (w_take) begin
                r_out <= r_skd;
            end
        end else if (w_adv) begin
            if (!r_out_valid || w_take) begin
                r_out <= w_res;
            end else begin
                r_skd <= w_res;
            end
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_byte_valid        = r_out.byte_valid;
    assign o_payload_byte      = r_out.payload_byte;
    assign o_section           = r_out.section;
    assign o_frame_done        = r_out.frame_done;
    assign o_is_identification = r_out.is_identification;
    assign o_frame_id          = r_out.frame_id;
    assign o_frame_status      = r_out.frame_status;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skd_valid |-> r_out_valid)
        else $error("skid holds a result while the result register is empty");

    a_summary_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.frame_done) |->
            (r_out.frame_status == ST_OK && !r_out.is_identification
             && r_out.frame_id == 32'd0))
        else $error("frame summary outside the last byte");

    a_empty_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.byte_valid) |->
            (r_out.payload_byte == 8'd0 && r_out.section == SEC_DATA))
        else $error("empty slot carries payload");

    a_zero_id_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.frame_status == ST_ZERO_ID) |->
            (r_out.is_identification && r_out.frame_id == 32'd0))
        else $error("zero identifier status on a data frame or nonzero id");

    a_stall_needs_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_out_valid && r_skd_valid))
        else $error("input stalled with room in the result stages");

endmodule
